// ----- design/acal_pkg.sv -----
// acal_pkg: shared widths, operation codes and types for the age-LRU cache.
// Used by acal_mem, acal_scan and assoc_cache_age_lru.
package acal_pkg;

  localparam int NUM_ENTRIES_DEF = 16;

  localparam int KEY_W  = 64;
  localparam int PAY_W  = 64;
  localparam int LEN_W  = 17;
  localparam int AGE_W  = 16;
  localparam int SLOT_W = 6;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // Operation codes carried on func
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // Control for one compare step of the scan unit
  typedef struct packed {
    logic vld;     // a table row is presented this cycle
    logic first;   // row 0: restart the running result
    logic insert;  // victim search instead of key match
  } scan_step_t;

endpackage

// ----- design/assoc_cache_age_lru.sv -----
// Fully associative cache of NUM_ENTRIES entries with per-entry age counters.
// Every request scans the whole table through one read port and a shared
// compare unit, one entry per cycle; the compare step works on the registered
// read data. After the scan comes a finish state, which waits for a free
// output register, then an idle state in which the next beat is taken. A lookup
// returns the lowest matching valid entry; an insert fills the first invalid
// entry or the oldest one, ages all others by one (saturating) during the
// scan, and writes the new entry with age zero. The next request is taken
// while the result waits in the output register.
module assoc_cache_age_lru #(
  parameter int NUM_ENTRIES = acal_pkg::NUM_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic [acal_pkg::KEY_W-1:0]  key,
  input  logic [acal_pkg::PAY_W-1:0]  payload,
  input  logic [acal_pkg::LEN_W-1:0]  length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic [acal_pkg::SLOT_W-1:0] slot,
  output logic [acal_pkg::LEN_W-1:0]  stored_length,
  output logic [acal_pkg::PAY_W-1:0]  stored_payload
);

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END = CW'(NUM_ENTRIES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                 state;
  logic [CW-1:0]              cnt;
  logic                       cmp_vld;
  logic [IW-1:0]              cmp_idx;
  logic [NUM_ENTRIES-1:0]     valid;

  // captured request beat
  logic                       req_func;
  logic [acal_pkg::KEY_W-1:0] req_key;
  logic [acal_pkg::PAY_W-1:0] req_payload;
  logic [acal_pkg::LEN_W-1:0] req_length;

  logic [acal_pkg::KEY_W-1:0] rd_key;
  logic [acal_pkg::PAY_W-1:0] rd_payload;
  logic [acal_pkg::LEN_W-1:0] rd_length;
  logic [acal_pkg::AGE_W-1:0] rd_age;

  logic [IW-1:0]              wr_addr;
  logic                       wr_age_en;
  logic [acal_pkg::AGE_W-1:0] wr_age;
  logic                       wr_entry_en;

  acal_pkg::scan_step_t       step;
  logic                       found;
  logic [IW-1:0]              best_idx;
  logic [acal_pkg::LEN_W-1:0] found_length;
  logic [acal_pkg::PAY_W-1:0] found_payload;

  logic                       in_fire;
  logic                       fin_fire;
  logic                       req_insert;

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign fin_fire   = (state == ST_FINISH) && (!out_valid || out_ready);
  assign req_insert = (req_func == acal_pkg::FUNC_INSERT);

  // compare step control
  always_comb begin
    step.vld    = cmp_vld;
    step.first  = (cmp_idx == '0);
    step.insert = req_insert;
  end

  // table write: aging during an insert scan, new entry at finish
  always_comb begin
    wr_entry_en = fin_fire && req_insert;
    if (wr_entry_en) begin
      wr_addr   = best_idx;
      wr_age_en = 1'b1;
      wr_age    = '0;
    end else begin
      wr_addr   = cmp_idx;
      wr_age_en = cmp_vld && req_insert;
      wr_age    = (rd_age == acal_pkg::AGE_MAX) ? rd_age : rd_age + 1'b1;
    end
  end

  acal_mem #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .IW          (IW)
  ) u_mem (
    .clk         (clk),
    .rd_addr     (cnt[IW-1:0]),
    .rd_key      (rd_key),
    .rd_payload  (rd_payload),
    .rd_length   (rd_length),
    .rd_age      (rd_age),
    .wr_addr     (wr_addr),
    .wr_age_en   (wr_age_en),
    .wr_age      (wr_age),
    .wr_entry_en (wr_entry_en),
    .wr_key      (req_key),
    .wr_payload  (req_payload),
    .wr_length   (req_length)
  );

  acal_scan #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .IW          (IW)
  ) u_scan (
    .clk           (clk),
    .step          (step),
    .row_idx       (cmp_idx),
    .row_valid     (valid[cmp_idx]),
    .row_key       (rd_key),
    .row_payload   (rd_payload),
    .row_length    (rd_length),
    .row_age       (rd_age),
    .req_key       (req_key),
    .found         (found),
    .best_idx      (best_idx),
    .found_length  (found_length),
    .found_payload (found_payload)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_func    <= func;
      req_key     <= key;
      req_payload <= payload;
      req_length  <= length;
    end
  end

  // sequencer: read rows 0..N-1, compare each in the cycle after its read, then finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      cmp_vld <= 1'b0;
      valid   <= '0;
    end else begin
      cmp_vld <= (state == ST_SCAN) && (cnt < CNT_END);
      cmp_idx <= cnt[IW-1:0];
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_fire) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt == CNT_END) begin
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          if (fin_fire) begin
            state <= ST_IDLE;
            if (req_insert) begin
              valid[best_idx] <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      if (req_insert) begin
        hit            <= 1'b1;
        slot           <= acal_pkg::SLOT_W'(best_idx);
        stored_length  <= req_length;
        stored_payload <= req_payload;
      end else if (found) begin
        hit            <= 1'b1;
        slot           <= acal_pkg::SLOT_W'(best_idx);
        stored_length  <= found_length;
        stored_payload <= found_payload;
      end else begin
        hit            <= 1'b0;
        slot           <= '0;
        stored_length  <= '0;
        stored_payload <= '0;
      end
    end
  end

endmodule

// ----- design/acal_mem.sv -----
// acal_mem: table storage for key, payload, length and age of every entry.
// One write address and one read address per cycle, registered read data.
// Depends on acal_pkg.
module acal_mem #(
  parameter int NUM_ENTRIES = acal_pkg::NUM_ENTRIES_DEF,
  parameter int IW          = $clog2(NUM_ENTRIES)
) (
  input  logic                       clk,
  input  logic [IW-1:0]              rd_addr,
  output logic [acal_pkg::KEY_W-1:0] rd_key,
  output logic [acal_pkg::PAY_W-1:0] rd_payload,
  output logic [acal_pkg::LEN_W-1:0] rd_length,
  output logic [acal_pkg::AGE_W-1:0] rd_age,
  input  logic [IW-1:0]              wr_addr,
  input  logic                       wr_age_en,
  input  logic [acal_pkg::AGE_W-1:0] wr_age,
  input  logic                       wr_entry_en,
  input  logic [acal_pkg::KEY_W-1:0] wr_key,
  input  logic [acal_pkg::PAY_W-1:0] wr_payload,
  input  logic [acal_pkg::LEN_W-1:0] wr_length
);

  logic [acal_pkg::KEY_W-1:0] key_mem     [NUM_ENTRIES];
  logic [acal_pkg::PAY_W-1:0] payload_mem [NUM_ENTRIES];
  logic [acal_pkg::LEN_W-1:0] length_mem  [NUM_ENTRIES];
  logic [acal_pkg::AGE_W-1:0] age_mem     [NUM_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_age_en) begin
      age_mem[wr_addr] <= wr_age;
    end
    if (wr_entry_en) begin
      key_mem[wr_addr]     <= wr_key;
      payload_mem[wr_addr] <= wr_payload;
      length_mem[wr_addr]  <= wr_length;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_key     <= key_mem[rd_addr];
    rd_payload <= payload_mem[rd_addr];
    rd_length  <= length_mem[rd_addr];
    rd_age     <= age_mem[rd_addr];
  end

endmodule

// ----- design/acal_scan.sv -----
// acal_scan: shared compare unit, one table row per step. Tracks the first
// key match (lookup) or the insert victim: first invalid row, else oldest.
// Depends on acal_pkg.
module acal_scan #(
  parameter int NUM_ENTRIES = acal_pkg::NUM_ENTRIES_DEF,
  parameter int IW          = $clog2(NUM_ENTRIES)
) (
  input  logic                       clk,
  input  acal_pkg::scan_step_t       step,
  input  logic [IW-1:0]              row_idx,
  input  logic                       row_valid,
  input  logic [acal_pkg::KEY_W-1:0] row_key,
  input  logic [acal_pkg::PAY_W-1:0] row_payload,
  input  logic [acal_pkg::LEN_W-1:0] row_length,
  input  logic [acal_pkg::AGE_W-1:0] row_age,
  input  logic [acal_pkg::KEY_W-1:0] req_key,
  output logic                       found,
  output logic [IW-1:0]              best_idx,
  output logic [acal_pkg::LEN_W-1:0] found_length,
  output logic [acal_pkg::PAY_W-1:0] found_payload
);

  logic                       have_inv;
  logic                       have_old;
  logic [acal_pkg::AGE_W-1:0] best_age;

  logic                       base_found;
  logic                       base_inv;
  logic                       base_old;

  // row 0 starts from an empty running result
  always_comb begin
    base_found = step.first ? 1'b0 : found;
    base_inv   = step.first ? 1'b0 : have_inv;
    base_old   = step.first ? 1'b0 : have_old;
  end

  always_ff @(posedge clk) begin
    if (step.vld) begin
      found    <= base_found;
      have_inv <= base_inv;
      have_old <= base_old;
      if (!step.insert) begin
        // lookup: keep lowest matching valid row
        if (!base_found && row_valid && (row_key == req_key)) begin
          found         <= 1'b1;
          best_idx      <= row_idx;
          found_length  <= row_length;
          found_payload <= row_payload;
        end
      end else if (!base_inv) begin
        // insert: first invalid row wins outright, else strictly older row
        if (!row_valid) begin
          have_inv <= 1'b1;
          best_idx <= row_idx;
        end else if (!base_old || (row_age > best_age)) begin
          have_old <= 1'b1;
          best_age <= row_age;
          best_idx <= row_idx;
        end
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for assoc_cache_age_lru (age-LRU associative cache).
// Depends on acal_pkg and the assoc_cache_age_lru RTL; drives directed then
// random lookup/insert beats, checks results against a shadow table or typed rows.
`timescale 1ns / 100ps

module tb;
  import acal_pkg::*;

  localparam int N_ENT       = NUM_ENTRIES_DEF;
  localparam int N_RANDOM    = 850;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 3 * (N_ENT + 3);
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    logic [LEN_W-1:0] len;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  pay;
  } res_t;

  // One stimulus row; typed rows carry a result read straight off the spec
  typedef struct packed {
    req_t req;
    logic typed;
    res_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              func = FUNC_LOOKUP;
  logic [KEY_W-1:0]  key = '0;
  logic [PAY_W-1:0]  payload = '0;
  logic [LEN_W-1:0]  length = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic [LEN_W-1:0]  stored_length;
  logic [PAY_W-1:0]  stored_payload;

  // Shadow copy of the cache table
  logic             tbl_valid [N_ENT];
  logic [AGE_W-1:0] tbl_age   [N_ENT];
  logic [KEY_W-1:0] tbl_key   [N_ENT];
  logic [PAY_W-1:0] tbl_pay   [N_ENT];
  logic [LEN_W-1:0] tbl_len   [N_ENT];

  stim_row_t        directed_rows[$];
  res_t             pending_results[$];
  logic [KEY_W-1:0] recent_keys[$];

  int n_fail = 0;
  int n_results = 0;
  int n_lookups = 0;
  int n_hits = 0;
  int n_inserts = 0;
  int n_evicts = 0;
  int cycle_cnt = 0;

  assoc_cache_age_lru u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .key            (key),
    .payload        (payload),
    .length         (length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .slot           (slot),
    .stored_length  (stored_length),
    .stored_payload (stored_payload)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow table update for one accepted request; returns the cache answer
  function automatic res_t cache_access(req_t r);
    res_t o;
    int   victim;
    o = '0;
    if (r.func == FUNC_LOOKUP) begin
      n_lookups++;
      // scan downward so the lowest matching index wins
      for (int i = N_ENT - 1; i >= 0; i--) begin
        if (tbl_valid[i] && tbl_key[i] == r.key) begin
          o.hit  = 1'b1;
          o.slot = SLOT_W'(i);
          o.len  = tbl_len[i];
          o.pay  = tbl_pay[i];
        end
      end
      if (o.hit) n_hits++;
      return o;
    end
    n_inserts++;
    // first free entry, else oldest with ties to the lowest index
    victim = -1;
    for (int i = 0; i < N_ENT; i++) begin
      if (!tbl_valid[i]) begin
        victim = i;
        break;
      end
    end
    if (victim < 0) begin
      n_evicts++;
      victim = 0;
      for (int i = 1; i < N_ENT; i++)
        if (tbl_age[i] > tbl_age[victim]) victim = i;
    end
    tbl_valid[victim] = 1'b1;
    tbl_key[victim]   = r.key;
    tbl_pay[victim]   = r.pay;
    tbl_len[victim]   = r.len;
    for (int i = 0; i < N_ENT; i++) begin
      if (i == victim) tbl_age[i] = '0;
      else if (tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 1'b1;
    end
    o.hit  = 1'b1;
    o.slot = SLOT_W'(victim);
    o.len  = r.len;
    o.pay  = r.pay;
    return o;
  endfunction

  function automatic void add_row(logic f, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                                  logic [LEN_W-1:0] l, logic typed, res_t want);
    stim_row_t row;
    row.req   = '{func: f, key: k, pay: p, len: l};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Random request: mostly lookups of recently inserted keys and fresh inserts
  function automatic stim_row_t random_row();
    stim_row_t row;
    int        pick;
    row = '0;
    pick = $urandom_range(0, 99);
    row.req.key = {$urandom, $urandom};
    row.req.pay = {$urandom, $urandom};
    row.req.len = LEN_W'($urandom_range(0, 131071));
    case ($urandom_range(0, 19))
      0: row.req.key = '0;
      1: row.req.key = '1;
      2: row.req.len = '1;
      3: row.req.len = '0;
      4: row.req.pay = '1;
      default: ;
    endcase
    if (pick < 45 && recent_keys.size() > 0) begin
      row.req.func = FUNC_LOOKUP;
      row.req.key  = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    end else if (pick < 60) begin
      row.req.func = FUNC_LOOKUP;
    end else begin
      row.req.func = FUNC_INSERT;
      // a few inserts reuse a recent key to make duplicates
      if (pick >= 95 && recent_keys.size() > 0)
        row.req.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      else begin
        recent_keys.push_back(row.req.key);
        if (recent_keys.size() > 40) void'(recent_keys.pop_front());
      end
    end
    return row;
  endfunction

  // Wait draw: bursts with no gaps around the stall windows, else rotating modes
  function automatic int draw_gap(int idx);
    if ((idx >= 25 && idx < 90) || (idx >= 395 && idx < 460)) return 0;
    case ((idx / 64) % 4)
      0: return 0;
      1: return $urandom_range(0, 19);
      2: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // Offer one beat, hold it until taken, then log its expected answer
  task automatic send_beat(stim_row_t row, int gap);
    res_t want;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= row.req.func;
    key      <= row.req.key;
    payload  <= row.req.pay;
    length   <= row.req.len;
    do @(posedge clk); while (!in_ready);
    want = cache_access(row.req);
    if (row.typed) want = row.want;
    pending_results.push_back(want);
  endtask

  function automatic void check_result();
    res_t want;
    n_results++;
    if (pending_results.size() == 0) begin
      $error("unexpected result beat: slot %0d hit %0d", slot, hit);
      n_fail++;
      return;
    end
    want = pending_results.pop_front();
    if (hit !== want.hit) begin
      $error("hit: expected %0d, got %0d", want.hit, hit);
      n_fail++;
    end
    if (slot !== want.slot) begin
      $error("slot: expected %0d, got %0d", want.slot, slot);
      n_fail++;
    end
    if (stored_length !== want.len) begin
      $error("stored_length: expected %0d, got %0d", want.len, stored_length);
      n_fail++;
    end
    if (stored_payload !== want.pay) begin
      $error("stored_payload: expected %h, got %h", want.pay, stored_payload);
      n_fail++;
    end
  endfunction

  // Result side: random back-pressure plus two long hold-offs
  initial begin : result_sink
    int wait_n;
    while (rst) @(posedge clk);
    forever begin
      wait_n = draw_gap(n_results);
      if (n_results == 30 || n_results == 400) wait_n = HOLD_CYCLES;
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result();
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
             pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    res_t miss;
    int   n_sent;
    miss = '0;
    n_sent = 0;
    for (int i = 0; i < N_ENT; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_age[i]   = '0;
      tbl_key[i]   = '0;
      tbl_pay[i]   = '0;
      tbl_len[i]   = '0;
    end

    // Directed table: empty-table misses, field extremes, duplicates, fill, eviction
    add_row(FUNC_LOOKUP, '0, '0, '0, 1'b1, miss);
    add_row(FUNC_LOOKUP, '1, '1, '1, 1'b1, miss);
    add_row(FUNC_INSERT, '0, '0, '0, 1'b1, '{hit: 1'b1, slot: 0, len: '0, pay: '0});
    add_row(FUNC_INSERT, '1, '1, '1, 1'b1, '{hit: 1'b1, slot: 1, len: '1, pay: '1});
    add_row(FUNC_LOOKUP, '1, 64'h5555_5555_5555_5555, 17'h0AAAA, 1'b1,
            '{hit: 1'b1, slot: 1, len: '1, pay: '1});
    add_row(FUNC_LOOKUP, '0, '1, '1, 1'b1, '{hit: 1'b1, slot: 0, len: '0, pay: '0});
    add_row(FUNC_INSERT, '1, 64'hA5A5_A5A5_A5A5_A5A5, 17'd1, 1'b1,
            '{hit: 1'b1, slot: 2, len: 17'd1, pay: 64'hA5A5_A5A5_A5A5_A5A5});
    // duplicate key: lowest copy answers
    add_row(FUNC_LOOKUP, '1, '0, '0, 1'b1, '{hit: 1'b1, slot: 1, len: '1, pay: '1});
    for (int i = 3; i < N_ENT; i++)
      add_row(FUNC_INSERT, 64'h8000_0000_0000_0100 + i, {$urandom, $urandom},
              LEN_W'(i * 4097), 1'b0, miss);
    // table full: evictions hit the oldest entries first
    add_row(FUNC_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 17'h10000,
            1'b0, miss);
    add_row(FUNC_LOOKUP, '0, '0, '0, 1'b0, miss);
    add_row(FUNC_INSERT, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000, 17'h0FFFF,
            1'b0, miss);
    add_row(FUNC_LOOKUP, '1, '0, '0, 1'b0, miss);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i], n_sent == 0 ? 0 : draw_gap(n_sent));
      n_sent++;
    end
    repeat (N_RANDOM) begin
      send_beat(random_row(), draw_gap(n_sent));
      n_sent++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d beats: %0d lookups (%0d hits), %0d inserts", n_sent, n_lookups,
             n_hits, n_inserts);
    $display("%0d inserts replaced a live entry; %0d results checked in %0d cycles",
             n_evicts, n_results, cycle_cnt);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/acal_pkg.sv
design/acal_mem.sv
design/acal_scan.sv
design/assoc_cache_age_lru.sv
bench/tb.sv
